FILE: hdl/oarb_pkg.sv
// Shared types and constants for the overlap-add ring buffer.
package oarb_pkg;

  typedef enum logic [2:0] {
    CMD_WRITE      = 3'd0,
    CMD_ACCUMULATE = 3'd1,
    CMD_READ       = 3'd2,
    CMD_READ_CLEAR = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_ADVANCE    = 3'd5,
    CMD_CLEAR_ALL  = 3'd6
  } cmd_e;

  localparam int unsigned CMD_W       = 3;
  localparam int unsigned REL_W       = 11;
  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned STEP_W      = 11;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned REL_SPAN    = 1024;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned OUT_DEPTH   = 4;

  typedef struct packed {
    logic [6:0]          pad;
    logic [STEP_W-1:0]   advance_by;
    logic [SAMPLE_W-1:0] sample;
    logic [REL_W-1:0]    rel_pos;
    cmd_e                command;
  } in_item_t;

  function automatic logic cmd_known(input cmd_e c);
    logic known;
    unique case (c)
      CMD_WRITE, CMD_ACCUMULATE, CMD_READ, CMD_READ_CLEAR,
      CMD_CLEAR, CMD_ADVANCE, CMD_CLEAR_ALL: known = 1'b1;
      default:                               known = 1'b0;
    endcase
    return known;
  endfunction

endpackage

FILE: hdl/overlap_add_ring_buffer_unit.sv
// Top level of the overlap-add ring buffer: front end, command queue and back end.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       command, rel_pos, sample, advance_by
//  m_axis    out  m_axis_tvalid/tready       read_value (reads only)
//
// One item per cycle when nothing stalls; the front end registers s1, s2 and s3 feed the queue.
// A read result goes from the queue through store stage b into the result buffer to m_axis.
// Reset and the clear-all command each run a sweep that zeroes every store entry;
// the back end takes no item meanwhile while the front end fills its queue.
// Reads wait at the store when the 4-entry result buffer could overflow.
module overlap_add_ring_buffer_unit #(
  parameter int unsigned BUFFER_SIZE = 1024,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // command[2:0], rel_pos[13:3], sample[37:14], advance_by[48:38], zero[55:49]
  input  logic [oarb_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // read_value[23:0]
  output logic [oarb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);

  localparam int unsigned ADDR_W = $clog2(BUFFER_SIZE);
  localparam int unsigned QW     = oarb_pkg::CMD_W + oarb_pkg::SAMPLE_W + ADDR_W;

  oarb_pkg::in_item_t in_item;
  logic               fq_valid, fq_ready, bq_valid, bq_ready;
  logic [QW-1:0]      fq_data, bq_data;

  assign in_item = s_axis_tdata_i;

  oarb_front #(
    .BUFFER_SIZE (BUFFER_SIZE),
    .ADDR_W      (ADDR_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_item_i  (in_item),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_data_o   (fq_data)
  );

  oarb_fifo #(
    .WIDTH (QW),
    .DEPTH (oarb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fq_valid),
    .in_ready_o  (fq_ready),
    .in_data_i   (fq_data),
    .out_valid_o (bq_valid),
    .out_ready_i (bq_ready),
    .out_data_o  (bq_data),
    .count_o     ()
  );

  oarb_back #(
    .BUFFER_SIZE (BUFFER_SIZE),
    .SAMPLE_BITS (SAMPLE_BITS),
    .ADDR_W      (ADDR_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (bq_valid),
    .q_ready_o   (bq_ready),
    .q_data_i    (bq_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

FILE: hdl/oarb_ram.sv
// Generic simple dual-port RAM with registered read.
module oarb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/oarb_fifo.sv
// Small register FIFO with fill count.
module oarb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [WIDTH-1:0]         in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [WIDTH-1:0]         out_data_o,
  output logic [$clog2(DEPTH):0]   count_o
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [PW:0]      count_q, count_d;
  logic             push, pop;

  assign in_ready_o  = (count_q != (PW+1)'(DEPTH));
  assign out_valid_o = (count_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign count_o     = count_q;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    count_d  = count_q + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

FILE: hdl/oarb_front.sv
// Front end: accepts items, drops unused commands, reduces offsets modulo the buffer size.
module oarb_front #(
  parameter int unsigned BUFFER_SIZE = 1024,
  parameter int unsigned ADDR_W      = $clog2(BUFFER_SIZE)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  oarb_pkg::in_item_t      in_item_i,
  output logic                    q_valid_o,
  input  logic                    q_ready_i,
  output logic [oarb_pkg::CMD_W+oarb_pkg::SAMPLE_W+ADDR_W-1:0] q_data_o
);

  localparam int unsigned XW   = $clog2(2048 + BUFFER_SIZE);
  localparam int unsigned KOFF = BUFFER_SIZE *
                                 ((oarb_pkg::REL_SPAN + BUFFER_SIZE - 1) / BUFFER_SIZE);
  localparam int unsigned PW   = XW + 32;
  localparam logic [31:0]   RECIP  = 32'((64'd1 << 32) / 64'(BUFFER_SIZE));
  localparam logic [XW-1:0] KOFF_X = XW'(KOFF);
  localparam logic [XW-1:0] N_X    = XW'(BUFFER_SIZE);

  logic                          en, accept;
  logic [XW-1:0]                 x_d, r_d, off_full;
  logic [PW-1:0]                 prod_d;
  logic [XW-1:0]                 quot;

  logic                          s1_valid_q, s2_valid_q, s3_valid_q;
  oarb_pkg::cmd_e                s1_cmd_q, s2_cmd_q, s3_cmd_q;
  logic [oarb_pkg::SAMPLE_W-1:0] s1_sample_q, s2_sample_q, s3_sample_q;
  logic [XW-1:0]                 s1_x_q, s2_x_q, s3_r_q;
  logic [PW-1:0]                 s2_prod_q;

  assign en         = !s3_valid_q || q_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  always_comb begin
    if (in_item_i.command == oarb_pkg::CMD_ADVANCE) begin
      x_d = {{(XW-oarb_pkg::STEP_W){1'b0}}, in_item_i.advance_by};
    end else begin
      x_d = KOFF_X + {{(XW-oarb_pkg::REL_W){in_item_i.rel_pos[oarb_pkg::REL_W-1]}},
                      in_item_i.rel_pos};
    end
  end

  // quotient estimate is exact or one low; the compare at the queue fixes it
  assign prod_d   = PW'(s1_x_q) * PW'(RECIP);
  assign quot     = s2_prod_q[PW-1:32];
  assign r_d      = s2_x_q - quot * N_X;
  assign off_full = (s3_r_q >= N_X) ? s3_r_q - N_X : s3_r_q;

  assign q_valid_o = s3_valid_q;
  assign q_data_o  = {s3_cmd_q, s3_sample_q, off_full[ADDR_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= accept && oarb_pkg::cmd_known(in_item_i.command);
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_cmd_q    <= in_item_i.command;
      s1_sample_q <= in_item_i.sample;
      s1_x_q      <= x_d;
      s2_cmd_q    <= s1_cmd_q;
      s2_sample_q <= s1_sample_q;
      s2_x_q      <= s1_x_q;
      s2_prod_q   <= prod_d;
      s3_cmd_q    <= s2_cmd_q;
      s3_sample_q <= s2_sample_q;
      s3_r_q      <= r_d;
    end
  end

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && !q_ready_i |=> s3_valid_q && $stable(s3_r_q))
    else $error("front output changed while stalled");

  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> off_full < N_X)
    else $error("offset not reduced below buffer size");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && s2_valid_q |=> s3_valid_q)
    else $error("item lost in front pipeline");

endmodule

FILE: hdl/oarb_back.sv
// Back end: write pointer, sample store, clear sweep and result buffer.
module oarb_back #(
  parameter int unsigned BUFFER_SIZE = 1024,
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned ADDR_W      = $clog2(BUFFER_SIZE)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  output logic                    q_ready_o,
  input  logic [oarb_pkg::CMD_W+oarb_pkg::SAMPLE_W+ADDR_W-1:0] q_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [oarb_pkg::OUT_TDATA_W-1:0] out_data_o
);

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned SW  = oarb_pkg::SAMPLE_W;
  localparam int unsigned EW  = ((SB > SW) ? SB : SW) + 1;
  localparam int unsigned QW  = oarb_pkg::CMD_W + SW + ADDR_W;
  localparam int unsigned CW  = $clog2(oarb_pkg::OUT_DEPTH) + 1;
  localparam logic [ADDR_W:0]   N_S  = (ADDR_W+1)'(BUFFER_SIZE);
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(BUFFER_SIZE - 1);

  function automatic logic [SB-1:0] sat(input logic [EW-1:0] v);
    logic [EW-SB:0] top;
    top = v[EW-1:SB-1];
    if ((top == '0) || (top == '1)) begin
      return v[SB-1:0];
    end
    return {v[EW-1], {(SB-1){~v[EW-1]}}};
  endfunction

  oarb_pkg::cmd_e    h_cmd;
  logic [SW-1:0]     h_sample;
  logic [ADDR_W-1:0] h_off, idx, wp_q, wp_d, clr_cnt_q, clr_cnt_d;
  logic [ADDR_W:0]   sum, sum_wrap;
  logic              h_elem, h_read, b_read, b_we, out_room, a_go, ram_re;
  logic              clearing_q, clearing_d;
  logic [CW-1:0]     out_count;
  logic              out_in_ready;

  logic              b_valid_q, b_fwd_q;
  oarb_pkg::cmd_e    b_cmd_q;
  logic [ADDR_W-1:0] b_addr_q;
  logic [SW-1:0]     b_sample_q;
  logic [SB-1:0]     b_fwd_data_q, ram_rdata, old, b_wdata;
  logic [EW-1:0]     old_ext, smp_ext, acc_sum;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [SB-1:0]     ram_wdata;

  assign h_cmd    = oarb_pkg::cmd_e'(q_data_i[QW-1 -: oarb_pkg::CMD_W]);
  assign h_sample = q_data_i[ADDR_W +: SW];
  assign h_off    = q_data_i[ADDR_W-1:0];

  assign sum      = {1'b0, wp_q} + {1'b0, h_off};
  assign sum_wrap = (sum >= N_S) ? sum - N_S : sum;
  assign idx      = sum_wrap[ADDR_W-1:0];

  always_comb begin
    unique case (h_cmd)
      oarb_pkg::CMD_WRITE, oarb_pkg::CMD_ACCUMULATE, oarb_pkg::CMD_CLEAR: begin
        h_elem = 1'b1;
        h_read = 1'b0;
      end
      oarb_pkg::CMD_READ, oarb_pkg::CMD_READ_CLEAR: begin
        h_elem = 1'b1;
        h_read = 1'b1;
      end
      default: begin
        h_elem = 1'b0;
        h_read = 1'b0;
      end
    endcase
  end

  assign b_read = b_valid_q && ((b_cmd_q == oarb_pkg::CMD_READ) ||
                                (b_cmd_q == oarb_pkg::CMD_READ_CLEAR));
  assign b_we   = b_valid_q && (b_cmd_q != oarb_pkg::CMD_READ);

  // reserve a result slot for every read held in the result buffer or in the store stage
  assign out_room  = ((CW+1)'(out_count) + (CW+1)'(b_read)) < (CW+1)'(oarb_pkg::OUT_DEPTH);
  assign a_go      = q_valid_i && !clearing_q && (!h_read || out_room);
  assign q_ready_o = a_go;
  assign ram_re    = a_go && h_elem;

  assign old     = b_fwd_q ? b_fwd_data_q : ram_rdata;
  assign old_ext = {{(EW-SB){old[SB-1]}}, old};
  assign smp_ext = {{(EW-SW){b_sample_q[SW-1]}}, b_sample_q};
  assign acc_sum = old_ext + smp_ext;

  always_comb begin
    unique case (b_cmd_q)
      oarb_pkg::CMD_WRITE:      b_wdata = sat(smp_ext);
      oarb_pkg::CMD_ACCUMULATE: b_wdata = sat(acc_sum);
      default:                  b_wdata = '0;
    endcase
  end

  always_comb begin
    if (clearing_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = b_we;
      ram_waddr = b_addr_q;
      ram_wdata = b_wdata;
    end
  end

  always_comb begin
    wp_d       = wp_q;
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + ADDR_W'(1);
      if (clr_cnt_q == LAST) begin
        clearing_d = 1'b0;
      end
    end else if (a_go) begin
      if (h_cmd == oarb_pkg::CMD_ADVANCE) begin
        wp_d = idx;
      end else if (h_cmd == oarb_pkg::CMD_CLEAR_ALL) begin
        wp_d       = '0;
        clearing_d = 1'b1;
        clr_cnt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      b_valid_q  <= 1'b0;
      b_fwd_q    <= 1'b0;
    end else begin
      wp_q       <= wp_d;
      clearing_q <= clearing_d;
      clr_cnt_q  <= clr_cnt_d;
      b_valid_q  <= ram_re;
      b_fwd_q    <= ram_re && b_we && (idx == b_addr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_go) begin
      b_cmd_q    <= h_cmd;
      b_addr_q   <= idx;
      b_sample_q <= h_sample;
    end
    b_fwd_data_q <= b_wdata;
  end

  oarb_ram #(
    .WIDTH (SB),
    .DEPTH (BUFFER_SIZE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx),
    .rdata_o (ram_rdata)
  );

  oarb_fifo #(
    .WIDTH (oarb_pkg::OUT_TDATA_W),
    .DEPTH (oarb_pkg::OUT_DEPTH)
  ) u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_read),
    .in_ready_o  (out_in_ready),
    .in_data_i   (old_ext[oarb_pkg::OUT_TDATA_W-1:0]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .count_o     (out_count)
  );

  a_no_issue_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !ram_re)
    else $error("store read issued during clear sweep");

  a_result_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_read |-> out_in_ready)
    else $error("result buffer overflow");

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= LAST)
    else $error("write pointer out of range");

  a_fwd_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_fwd_q |-> b_valid_q)
    else $error("bypass without an item in the store stage");

endmodule
